>>> rtl/stick_cartesian_to_polar_assert.svh
// assertion macros, included by the queue
`ifndef STICK_CARTESIAN_TO_POLAR_ASSERT_SVH
`define STICK_CARTESIAN_TO_POLAR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SCP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scp check failed");

// next-cycle implication, checked outside reset
`define SCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scp check failed");

`endif

>>> rtl/scp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

  // cordic geometry
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int GUARD_BITS       = 16;
  localparam int IN_W             = 16;
  // pre-rotated sample: 16-bit sample negated needs one more bit; two are added
  localparam int PRE_W            = IN_W + 2;
  // datapath: pre-rotated sample, guard bits, headroom for cordic gain
  localparam int DP_W             = PRE_W + GUARD_BITS + 2;
  localparam int ACC_W            = 32;
  localparam int OUT_W            = 16;

  // inverse cordic gain, q24
  localparam int INV_GAIN_W       = 24;
  localparam logic [INV_GAIN_W-1:0] INV_GAIN = 24'd10187995;

  // queue between front and back
  localparam int QUEUE_DEPTH      = 4;

  // fixed angles for the axis cases
  localparam logic [OUT_W-1:0] ANGLE_ZERO    = 16'd0;
  localparam logic [OUT_W-1:0] ANGLE_QUARTER = 16'd16384;
  localparam logic [OUT_W-1:0] ANGLE_HALF    = 16'd32768;
  localparam logic [OUT_W-1:0] ANGLE_3QUART  = 16'd49152;

  // classified beat handed from front to back
  typedef struct packed {
    logic signed [PRE_W-1:0] cx;
    logic signed [PRE_W-1:0] cy;
    logic                    half_turn;
    logic                    fix;
    logic [OUT_W-1:0]        fix_angle;
  } item_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [ACC_W-1:0] atan_turns(input int idx);
    logic [ACC_W-1:0] v;
    case (idx)
      0:       v = 32'd536870912;
      1:       v = 32'd316933406;
      2:       v = 32'd167458907;
      3:       v = 32'd85004756;
      4:       v = 32'd42667331;
      5:       v = 32'd21354465;
      6:       v = 32'd10679838;
      7:       v = 32'd5340245;
      8:       v = 32'd2670163;
      9:       v = 32'd1335087;
      10:      v = 32'd667544;
      11:      v = 32'd333772;
      12:      v = 32'd166886;
      13:      v = 32'd83443;
      14:      v = 32'd41722;
      15:      v = 32'd20861;
      16:      v = 32'd10430;
      17:      v = 32'd5215;
      18:      v = 32'd2608;
      19:      v = 32'd1304;
      20:      v = 32'd652;
      21:      v = 32'd326;
      22:      v = 32'd163;
      23:      v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/scp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_front
  import scp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [IN_W-1:0] axis_x,
  input  wire logic signed [IN_W-1:0] axis_y,
  output logic                        push,
  input  wire logic                   push_ready,
  output item_t                       push_item
);

  logic  held;
  item_t item;
  item_t item_next;

  // classify the sample: half-turn pre-rotation and axis cases
  always_comb begin
    logic signed [PRE_W-1:0] sx;
    logic signed [PRE_W-1:0] sy;
    sx = PRE_W'(axis_x);
    sy = PRE_W'(axis_y);
    item_next.half_turn = axis_x[IN_W-1];
    item_next.cx        = axis_x[IN_W-1] ? -sx : sx;
    item_next.cy        = axis_x[IN_W-1] ? -sy : sy;
    item_next.fix       = (axis_x == '0) || (axis_y == '0);
    if (axis_x == '0 && axis_y == '0) begin
      item_next.fix_angle = ANGLE_ZERO;
    end else if (axis_x == '0) begin
      item_next.fix_angle = axis_y[IN_W-1] ? ANGLE_3QUART : ANGLE_QUARTER;
    end else begin
      item_next.fix_angle = axis_x[IN_W-1] ? ANGLE_HALF : ANGLE_ZERO;
    end
  end

  assign push      = held && push_ready;
  assign in_ready  = !held || push_ready;
  assign push_item = item;

  // one-beat holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/scp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_queue
  import scp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop,
  output item_t      pop_item
);

`include "stick_cartesian_to_polar_assert.svh"

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign push_ready = count != COUNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  `SCP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= COUNT_W'(QUEUE_DEPTH))
  `SCP_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, count != '0)
  `SCP_ASSERT_NOW(a_no_push_full, clk, rst, push, count != COUNT_W'(QUEUE_DEPTH))
  `SCP_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

`default_nettype wire

>>> rtl/scp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module scp_back
  import scp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pop_valid,
  output logic             pop,
  input  wire item_t       pop_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [OUT_W-1:0] angle_turns,
  output logic [OUT_W-1:0] radius_mag
);

  localparam int LO_W   = 17;
  localparam int HI_W   = DP_W - 1 - LO_W;
  localparam int PLO_W  = LO_W + INV_GAIN_W;
  localparam int PHI_W  = HI_W + INV_GAIN_W;
  localparam int SUM_W  = PHI_W + LO_W + 1;
  localparam int RSHIFT = 40;
  localparam int RAD_W  = SUM_W - RSHIFT;
  localparam int EXT_W  = DP_W - PRE_W - GUARD_BITS;

  // whole pipeline advances unless the output beat is stalled
  logic adv;
  assign adv = !out_valid || out_ready;
  assign pop = adv && pop_valid;

  // cordic stage registers
  logic                    sv   [CORDIC_STEPS+1];
  logic signed [DP_W-1:0]  sx   [CORDIC_STEPS+1];
  logic signed [DP_W-1:0]  sy   [CORDIC_STEPS+1];
  logic [ACC_W-1:0]        sacc [CORDIC_STEPS+1];
  logic                    sfix [CORDIC_STEPS+1];
  logic [OUT_W-1:0]        sang [CORDIC_STEPS+1];

  // load stage: apply guard bits and the half-turn start angle
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx[0]   <= {{EXT_W{pop_item.cx[PRE_W-1]}}, pop_item.cx, GUARD_BITS'(0)};
      sy[0]   <= {{EXT_W{pop_item.cy[PRE_W-1]}}, pop_item.cy, GUARD_BITS'(0)};
      sacc[0] <= {pop_item.half_turn, (ACC_W-1)'(0)};
      sfix[0] <= pop_item.fix;
      sang[0] <= pop_item.fix_angle;
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [DP_W-1:0] dx;
    logic signed [DP_W-1:0] dy;
    assign dx = sy[k] >>> k;
    assign dy = sx[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sy[k] >= 0) begin
          sx[k+1]   <= sx[k] + dx;
          sy[k+1]   <= sy[k] - dy;
          sacc[k+1] <= sacc[k] + atan_turns(k);
        end else begin
          sx[k+1]   <= sx[k] - dx;
          sy[k+1]   <= sy[k] + dy;
          sacc[k+1] <= sacc[k] - atan_turns(k);
        end
        sfix[k+1] <= sfix[k];
        sang[k+1] <= sang[k];
      end
    end
  end

  // gain stage: magnitude times inverse gain, split in two partial products
  logic [DP_W-2:0]  mag;
  logic             mv;
  logic [PLO_W-1:0] p_lo;
  logic [PHI_W-1:0] p_hi;
  logic [ACC_W-1:0] macc;
  logic             mfix;
  logic [OUT_W-1:0] mang;

  assign mag = sx[CORDIC_STEPS][DP_W-1] ? '0 : sx[CORDIC_STEPS][DP_W-2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (adv) begin
      mv <= sv[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_lo <= mag[LO_W-1:0] * INV_GAIN;
      p_hi <= mag[DP_W-2:LO_W] * INV_GAIN;
      macc <= sacc[CORDIC_STEPS];
      mfix <= sfix[CORDIC_STEPS];
      mang <= sang[CORDIC_STEPS];
    end
  end

  // output stage: sum, round, saturate, pick the angle
  logic [SUM_W-1:0] rsum;
  logic [RAD_W-1:0] rad;
  logic [ACC_W-1:0] acc_rnd;

  assign rsum    = {1'b0, p_hi, LO_W'(0)} + SUM_W'(p_lo) + (SUM_W'(1) << (RSHIFT - 1));
  assign rad     = rsum[SUM_W-1:RSHIFT];
  assign acc_rnd = macc + ACC_W'(32'h8000);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_turns <= mfix ? mang : acc_rnd[ACC_W-1:ACC_W-OUT_W];
      radius_mag  <= (rad[RAD_W-1:OUT_W] != '0) ? '1 : rad[OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/stick_cartesian_to_polar.sv
`timescale 1ns / 1ps
`default_nettype none

// Cartesian to polar conversion of a signed 16-bit stick sample pair. One
// (axis_x, axis_y) beat may be taken every clock while in_ready is high;
// each beat gives one result beat with angle_turns (a full turn is 65536)
// and radius_mag (magnitude, rounded, saturated at 65535). A beat passes
// through the front register, the queue, a load stage, one register per
// micro-rotation of the pipelined CORDIC, the gain multiply and the output
// register. The pipelined CORDIC, one micro-rotation per stage, sets the
// rate of one beat per cycle while the output is not stalled. A four-beat
// queue between the classifying front and the CORDIC back lets input
// acceptance carry on while the output is briefly stalled.

module stick_cartesian_to_polar
  import scp_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [IN_W-1:0]  axis_x,
  input  wire logic signed [IN_W-1:0]  axis_y,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [OUT_W-1:0]             angle_turns,
  output logic [OUT_W-1:0]             radius_mag
);

  logic  push;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop;
  item_t pop_item;

  // classify and hold the incoming beat
  scp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  scp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // cordic pipeline, gain and output register
  scp_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop         (pop),
    .pop_item    (pop_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .angle_turns (angle_turns),
    .radius_mag  (radius_mag)
  );

endmodule

`default_nettype wire

>>> tb/stick_cartesian_to_polar_tb.sv
`timescale 1ns / 1ps

module stick_cartesian_to_polar_tb;
  import scp_pkg::*;

  localparam int STEPS         = 16;
  localparam int TABLE_LEN     = 24;
  localparam int RANDOM_PER_PH = 450;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 60;

  // atan(2^-i) as a fraction of a full turn, 2^-32 units
  localparam logic [31:0] ATAN_STEP [TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
  } stick_sample_t;

  typedef struct packed {
    logic [OUT_W-1:0] angle;
    logic [OUT_W-1:0] radius;
  } polar_t;

  typedef struct packed {
    stick_sample_t src;
    polar_t        res;
  } polar_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [IN_W-1:0] axis_x = '0;
  logic signed [IN_W-1:0] axis_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [OUT_W-1:0] angle_turns;
  logic [OUT_W-1:0] radius_mag;

  stick_sample_t pending_samples[$];
  polar_expect_t expected_polar[$];
  int send_idle = 0;
  int recv_idle = 0;
  int error_count = 0;
  int cycle_count = 0;

  stick_cartesian_to_polar #(.CORDIC_STEPS(STEPS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .axis_x(axis_x),
    .axis_y(axis_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angle_turns(angle_turns),
    .radius_mag(radius_mag)
  );

  always #10 clk = ~clk;

  // vectoring cordic with half-turn pre-rotation and axis fix-ups
  function automatic polar_t polar_of(input logic signed [IN_W-1:0] ax,
                                      input logic signed [IN_W-1:0] ay);
    longint vx;
    longint vy;
    longint sx;
    longint sy;
    longint mag;
    logic [31:0] turn_acc;
    logic [31:0] rounded;
    polar_t r;
    r = '0;
    if (ax == 0 && ay == 0) return r;
    if (ax < 0) begin
      vx = -longint'(ax);
      vy = -longint'(ay);
      turn_acc = 32'h8000_0000;
    end else begin
      vx = longint'(ax);
      vy = longint'(ay);
      turn_acc = '0;
    end
    vx = vx * 65536;
    vy = vy * 65536;
    for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
      sx = vy >>> i;
      sy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + sx;
        vy = vy - sy;
        turn_acc = turn_acc + ATAN_STEP[i];
      end else begin
        vx = vx - sx;
        vy = vy + sy;
        turn_acc = turn_acc - ATAN_STEP[i];
      end
    end
    // round to 2^-16 turn, wrapping past a full turn
    rounded = turn_acc + 32'h0000_8000;
    r.angle = rounded[31:16];
    if (ax == 0) r.angle = (ay > 0) ? 16'd16384 : 16'd49152;
    else if (ay == 0) r.angle = (ax > 0) ? 16'd0 : 16'd32768;
    if (vx < 0) vx = 0;
    mag = (vx * 64'sd10187995 + (64'sd1 <<< 39)) >>> 40;
    if (mag > 65535) mag = 65535;
    r.radius = mag[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // random sample with bias towards the axes, extremes, small values and diagonals
  function automatic stick_sample_t random_sample();
    stick_sample_t s;
    logic [31:0] r1;
    logic [31:0] r2;
    logic signed [IN_W-1:0] corners [6];
    int mode;
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    r1 = $urandom;
    r2 = $urandom;
    mode = $urandom_range(0, 9);
    s.x = r1[15:0];
    s.y = r2[15:0];
    case (mode)
      4: s.x = '0;
      5: s.y = '0;
      6: begin
        s.x = IN_W'($signed($urandom_range(0, 16)) - 8);
        s.y = IN_W'($signed($urandom_range(0, 16)) - 8);
      end
      7: begin
        s.x = corners[$urandom_range(0, 5)];
        s.y = corners[$urandom_range(0, 5)];
      end
      8: s.y = IN_W'($signed($urandom_range(0, 6)) - 3);
      9: s.y = r2[0] ? s.x : -s.x;
      default: ;
    endcase
    return s;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // driver: records each accepted beat and presents the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_polar.push_back('{'{axis_x, axis_y}, polar_of(axis_x, axis_y)});
      if (!in_valid || in_ready) begin
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          stick_sample_t nxt;
          nxt = pending_samples.pop_front();
          axis_x <= nxt.x;
          axis_y <= nxt.y;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_polar.size() == 0) begin
        report_mismatch($sformatf("unexpected result angle %0d radius %0d",
                                  angle_turns, radius_mag));
      end else begin
        polar_expect_t e;
        e = expected_polar.pop_front();
        if (angle_turns !== e.res.angle)
          report_mismatch($sformatf("x %0d y %0d angle got %0d want %0d",
                                    e.src.x, e.src.y, angle_turns, e.res.angle));
        if (radius_mag !== e.res.radius)
          report_mismatch($sformatf("x %0d y %0d radius got %0d want %0d",
                                    e.src.x, e.src.y, radius_mag, e.res.radius));
      end
    end
  end

  initial begin
    int sender_pct [3];
    int receiver_pct [3];
    sender_pct = '{38, 63, 0};
    receiver_pct = '{63, 38, 0};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: origin, axes both ways, corners, diagonals, wrap near a full turn
    pending_samples.push_back('{16'sd0, 16'sd0});
    pending_samples.push_back('{16'sd0, 16'sd32767});
    pending_samples.push_back('{16'sd0, -16'sd32768});
    pending_samples.push_back('{16'sd0, 16'sd1});
    pending_samples.push_back('{16'sd0, -16'sd1});
    pending_samples.push_back('{16'sd32767, 16'sd0});
    pending_samples.push_back('{-16'sd32768, 16'sd0});
    pending_samples.push_back('{16'sd1, 16'sd0});
    pending_samples.push_back('{-16'sd1, 16'sd0});
    pending_samples.push_back('{16'sd32767, 16'sd32767});
    pending_samples.push_back('{-16'sd32768, -16'sd32768});
    pending_samples.push_back('{16'sd32767, -16'sd32768});
    pending_samples.push_back('{-16'sd32768, 16'sd32767});
    pending_samples.push_back('{16'sd1, 16'sd1});
    pending_samples.push_back('{-16'sd1, -16'sd1});
    pending_samples.push_back('{16'sd1, -16'sd1});
    pending_samples.push_back('{-16'sd1, 16'sd1});
    pending_samples.push_back('{16'sd32767, -16'sd1});
    pending_samples.push_back('{16'sd20000, -16'sd1});
    pending_samples.push_back('{-16'sd32768, 16'sd1});
    pending_samples.push_back('{-16'sd32768, -16'sd1});
    pending_samples.push_back('{16'sd32767, 16'sd1});
    pending_samples.push_back('{-16'sd21846, 16'sd12345});

    // three idling phases of random samples
    for (int ph = 0; ph < 3; ph++) begin
      @(negedge clk);
      send_idle = sender_pct[ph];
      recv_idle = receiver_pct[ph];
      for (int n = 0; n < RANDOM_PER_PH; n++)
        pending_samples.push_back(random_sample());
      while (pending_samples.size() > 0 || in_valid) @(negedge clk);
    end

    while (expected_polar.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0 && expected_polar.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/scp_pkg.sv
rtl/scp_front.sv
rtl/scp_queue.sv
rtl/scp_back.sv
rtl/stick_cartesian_to_polar.sv
tb/stick_cartesian_to_polar_tb.sv
